// ----- rtl/cfd_pkg.sv -----
// Shared constants, types and table functions of the modulated delay line.
package cfd_pkg;

    localparam int DELAY_DEPTH  = 4096;
    localparam int NUM_CHANNELS = 2;
    localparam int SAMPLE_BITS  = 16;
    localparam int ADDR_W       = $clog2(DELAY_DEPTH);
    localparam int FILL_W       = ADDR_W + 1;
    localparam int MEM_DEPTH    = NUM_CHANNELS * DELAY_DEPTH;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);

    localparam int PHASE_W = 19;
    localparam logic [PHASE_W-1:0] PHASE_WRAP = PHASE_W'(359 * 1024);

    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 13;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = 18;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLANGE_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REGEN_GAIN  = 3'd5;

    typedef struct packed {
        logic                          rd_en;
        logic                          wr_en;
        logic                          ch;
        logic [ADDR_W-1:0]             dly;
        logic signed [SAMPLE_BITS-1:0] wr_data;
    } dl_req_t;

    localparam logic [10:0] QSINE [0:90] = '{
        11'd0,    11'd17,   11'd35,   11'd53,   11'd71,   11'd89,   11'd107,  11'd124,
        11'd142,  11'd160,  11'd177,  11'd195,  11'd212,  11'd230,  11'd247,  11'd265,
        11'd282,  11'd299,  11'd316,  11'd333,  11'd350,  11'd366,  11'd383,  11'd400,
        11'd416,  11'd432,  11'd448,  11'd464,  11'd480,  11'd496,  11'd512,  11'd527,
        11'd542,  11'd557,  11'd572,  11'd587,  11'd601,  11'd616,  11'd630,  11'd644,
        11'd658,  11'd671,  11'd685,  11'd698,  11'd711,  11'd724,  11'd736,  11'd748,
        11'd760,  11'd772,  11'd784,  11'd795,  11'd806,  11'd817,  11'd828,  11'd838,
        11'd848,  11'd858,  11'd868,  11'd877,  11'd886,  11'd895,  11'd904,  11'd912,
        11'd920,  11'd928,  11'd935,  11'd942,  11'd949,  11'd955,  11'd962,  11'd968,
        11'd973,  11'd979,  11'd984,  11'd989,  11'd993,  11'd997,  11'd1001, 11'd1005,
        11'd1008, 11'd1011, 11'd1014, 11'd1016, 11'd1018, 11'd1020, 11'd1021, 11'd1022,
        11'd1023, 11'd1023, 11'd1024
    };

    function automatic logic signed [11:0] sine_at(input logic [8:0] deg_raw);
        logic [8:0]  deg;
        logic [8:0]  q;
        logic        neg;
        logic [10:0] mag;
        deg = (deg_raw >= 9'd360) ? deg_raw - 9'd360 : deg_raw;
        neg = (deg >= 9'd180);
        q   = neg ? deg - 9'd180 : deg;
        if (q > 9'd90)
        begin
            q = 9'd180 - q;
        end
        mag = QSINE[q[6:0]];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic signed [SUM_W-1:0] div256(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] biased;
        biased = p + (p[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
        return SUM_W'(biased >>> 8);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
        lo = -hi - SUM_W'(1);
        if (v > hi)
        begin
            return SAMPLE_BITS'(hi);
        end
        if (v < lo)
        begin
            return SAMPLE_BITS'(lo);
        end
        return SAMPLE_BITS'(v);
    endfunction

endpackage

// ----- rtl/cfd_mul.sv -----
// Shared signed multiplier with a registered product.
module cfd_mul
    import cfd_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/cfd_dline.sv -----
// Per-channel delay memory with write pointers and fill counts.
module cfd_dline
    import cfd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dl_req_t                       req,
    output logic signed [SAMPLE_BITS-1:0] tap
);

    logic [SAMPLE_BITS-1:0] mem [0:MEM_DEPTH-1];
    logic [ADDR_W-1:0]      wp_reg   [0:NUM_CHANNELS-1];
    logic [FILL_W-1:0]      fill_reg [0:NUM_CHANNELS-1];
    logic [SAMPLE_BITS-1:0] q_reg;
    logic                   hit_reg;
    logic [ADDR_W-1:0]      rd_idx;
    logic [ADDR_W-1:0]      wr_idx;
    logic                   hit;

    assign rd_idx = wp_reg[req.ch] - req.dly;
    assign wr_idx = wp_reg[req.ch] + ADDR_W'(1);
    assign hit    = {1'b0, req.dly} < fill_reg[req.ch];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[MEM_AW'({req.ch, wr_idx})] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg <= mem[MEM_AW'({req.ch, rd_idx})];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            if (req.rd_en)
            begin
                hit_reg <= hit;
            end
            if (req.wr_en)
            begin
                wp_reg[req.ch] <= wr_idx;
                if (fill_reg[req.ch] != FILL_W'(DELAY_DEPTH))
                begin
                    fill_reg[req.ch] <= fill_reg[req.ch] + FILL_W'(1);
                end
            end
        end
    end

    assign tap = hit_reg ? $signed(q_reg) : '0;

endmodule

// ----- rtl/chorus_flanger_delay_top.sv -----
// Top level of the chorus / flanger modulated delay line with its sequencer.
//
// Usage: one signed 16-bit sample and its channel bit arrive on the input
// channel (in_valid / in_ready); one mixed sample leaves on the output
// channel (out_valid / out_ready) for every input transfer, in order.
// Settings must be written through the cfg channel (cfg_valid / cfg_ready,
// cfg_index, cfg_data) while idle; not enforced, as cfg_ready is always high.
// Each sample passes a sequencer of six steps that share one multiplier:
// delay product, memory read, wet, dry and feedback products, write-back.
// The result is registered at the write-back step, and the next input is
// taken in the following cycle; no new sample is taken before the last is
// done, set by the four passes through the shared multiplier and the memory read.
// Reset clears the LFO phase, write pointers and fill counts and loads the
// default settings; delay memory entries not yet written since reset read
// as zero through the fill counts, so no clearing pass is needed.
// If the receiver stalls, the finished result waits in the output register
// and a further sample is held at its write-back step until that transfer.
module chorus_flanger_delay_top
    import cfd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          channel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_D = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_MUL_W = 3'd3;
    localparam logic [2:0] ST_MUL_X = 3'd4;
    localparam logic [2:0] ST_MUL_R = 3'd5;
    localparam logic [2:0] ST_WR    = 3'd6;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [15:0]                   lfo_step_reg;
    logic [5:0]                    mod_depth_reg;
    logic                          flange_mode_reg;
    logic [8:0]                    wet_gain_reg;
    logic [8:0]                    dry_gain_reg;
    logic [8:0]                    regen_gain_reg;
    logic [PHASE_W-1:0]            phase_reg;
    logic [PHASE_W-1:0]            phase_next;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          ch_reg;
    logic signed [SAMPLE_BITS-1:0] tap_reg;
    logic signed [SUM_W-1:0]       wet_reg;
    logic signed [SAMPLE_BITS-1:0] mix_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic                          out_valid_reg;

    logic signed [11:0]            sine;
    logic signed [11:0]            sine_div;
    logic [11:0]                   factor;
    logic signed [MUL_A_W-1:0]     op_a;
    logic signed [MUL_B_W-1:0]     op_b;
    logic signed [PROD_W-1:0]      prod;
    logic [PROD_W-1:0]             dly_raw;
    logic [ADDR_W-1:0]             dly;
    logic signed [SUM_W-1:0]       fb_sum;
    logic signed [SAMPLE_BITS-1:0] tap;
    logic                          out_free;
    logic                          wr_go;
    dl_req_t                       dl_req;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign wr_go     = (state_reg == ST_WR) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_step_reg    <= 16'd5;
            mod_depth_reg   <= 6'd50;
            flange_mode_reg <= 1'b0;
            wet_gain_reg    <= 9'd250;
            dry_gain_reg    <= 9'd200;
            regen_gain_reg  <= 9'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LFO_STEP:    lfo_step_reg    <= cfg_data;
                CFG_MOD_DEPTH:   mod_depth_reg   <= cfg_data[5:0];
                CFG_FLANGE_MODE: flange_mode_reg <= cfg_data[0];
                CFG_WET_GAIN:    wet_gain_reg    <= cfg_data[8:0];
                CFG_DRY_GAIN:    dry_gain_reg    <= cfg_data[8:0];
                CFG_REGEN_GAIN:  regen_gain_reg  <= cfg_data[8:0];
                default:         ;
            endcase
        end
    end

    // LFO tap factor: chorus uses the sine directly, flange a sixteenth of it
    always_comb
    begin
        sine     = sine_at(phase_reg[PHASE_W-1:10]);
        sine_div = sine[11] ? -12'((-sine) >>> 4) : 12'(sine >>> 4);
        if (flange_mode_reg)
        begin
            factor = 12'(12'sd1024 + sine_div);
        end
        else
        begin
            factor = 12'(12'sd1024 + sine);
        end
    end

    always_comb
    begin
        phase_next = phase_reg + PHASE_W'(lfo_step_reg);
        if (phase_next >= PHASE_WRAP)
        begin
            phase_next = '0;
        end
    end

    always_comb
    begin
        dly_raw = flange_mode_reg ? PROD_W'(prod[PROD_W-1:7]) : PROD_W'(prod[PROD_W-1:11]);
        dly     = (dly_raw > PROD_W'(DELAY_DEPTH - 1)) ? ADDR_W'(DELAY_DEPTH - 1)
                                                      : dly_raw[ADDR_W-1:0];
    end

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_MUL_D:
            begin
                op_a = MUL_A_W'({mod_depth_reg, 3'b000});
                op_b = MUL_B_W'(factor);
            end
            ST_MUL_W:
            begin
                op_a = MUL_A_W'(tap);
                op_b = MUL_B_W'(wet_gain_reg);
            end
            ST_MUL_X:
            begin
                op_a = MUL_A_W'(x_reg);
                op_b = MUL_B_W'(dry_gain_reg);
            end
            ST_MUL_R, ST_WR:
            begin
                op_a = MUL_A_W'(tap_reg);
                op_b = MUL_B_W'(regen_gain_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    cfd_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign fb_sum = div256(prod) + SUM_W'(x_reg);

    always_comb
    begin
        dl_req.rd_en   = (state_reg == ST_ADDR);
        dl_req.wr_en   = wr_go;
        dl_req.ch      = ch_reg;
        dl_req.dly     = dly;
        dl_req.wr_data = sat16(fb_sum);
    end

    cfd_dline u_dline (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dl_req),
        .tap   (tap)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D: state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_MUL_W;
            ST_MUL_W: state_next = ST_MUL_X;
            ST_MUL_X: state_next = ST_MUL_R;
            ST_MUL_R: state_next = ST_WR;
            ST_WR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL_D)
            begin
                phase_reg <= phase_next;
            end
            if (wr_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg  <= sample_in;
            ch_reg <= channel;
        end
        if (state_reg == ST_MUL_W)
        begin
            tap_reg <= tap;
        end
        if (state_reg == ST_MUL_X)
        begin
            wet_reg <= div256(prod);
        end
        if (state_reg == ST_MUL_R)
        begin
            mix_reg <= sat16(wet_reg + div256(prod));
        end
        if (wr_go)
        begin
            out_reg <= mix_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

endmodule
